[rtl/stlb_pkg.sv]
// Package for the split instruction/data TLB: sizes, register indexes,
// eviction modes, controller state and command/status types, LCG helper.
// No dependencies.
package stlb_pkg;

  localparam int INST_ENTRIES = 16;
  localparam int DATA_ENTRIES = 16;
  localparam int FRAME_BITS   = 20;

  localparam int MAX_ENTRIES = (INST_ENTRIES > DATA_ENTRIES) ? INST_ENTRIES : DATA_ENTRIES;
  localparam int INST_IW     = (INST_ENTRIES > 1) ? $clog2(INST_ENTRIES) : 1;
  localparam int DATA_IW     = (DATA_ENTRIES > 1) ? $clog2(DATA_ENTRIES) : 1;

  localparam int VADDR_W = 32;
  localparam int PAGE_W  = 20;
  localparam int FRAME_W = 20;
  localparam int LAT_W   = 10;
  localparam int CLAT_W  = 8;
  localparam int MODE_W  = 2;
  localparam int SEED_W  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [FRAME_W-1:0] FRAME_MASK =
    (FRAME_BITS >= FRAME_W) ? {FRAME_W{1'b1}} : FRAME_W'((64'd1 << FRAME_BITS) - 64'd1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INST_LAT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_LAT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WALK_LAT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EVICT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 3'd4;

  // eviction modes; any other code picks entry zero
  localparam logic [MODE_W-1:0] EVICT_SEQ  = 2'd0;
  localparam logic [MODE_W-1:0] EVICT_LCG  = 2'd1;
  localparam logic [MODE_W-1:0] EVICT_ZERO = 2'd2;

  localparam logic [CLAT_W-1:0] INST_LAT_RST = 8'd1;
  localparam logic [CLAT_W-1:0] DATA_LAT_RST = 8'd1;
  localparam logic [CLAT_W-1:0] WALK_LAT_RST = 8'd100;

  localparam logic [SEED_W-1:0] LCG_A = 32'd1664525;
  localparam logic [SEED_W-1:0] LCG_C = 32'd1013904223;
  // counters after loading seed zero
  localparam logic [SEED_W-1:0] INST_CNT_RST = LCG_C;
  localparam logic [SEED_W-1:0] DATA_CNT_RST = 32'(64'(LCG_C) * 64'(LCG_A) + 64'(LCG_C));

  // victim modulo: one 4-bit digit per step
  localparam int MOD_DIGIT = 4;
  localparam int MOD_STEPS = SEED_W / MOD_DIGIT;
  localparam int STEP_W    = $clog2(MOD_STEPS);
  localparam int REM_W     = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_MOD,
    S_EVICT
  } stlb_state_e;

  typedef struct packed {
    logic capture;   // latch request
    logic mod_load;  // load victim source, advance counter/LCG
    logic mod_step;  // one remainder digit
    logic finish;    // update TLB, load result
    logic use_rem;   // victim slot from remainder, else zero
  } stlb_cmd_t;

  typedef struct packed {
    logic hit;
    logic present;
    logic full;
    logic need_mod;
  } stlb_status_t;

  function automatic logic [SEED_W-1:0] lcg_next(input logic [SEED_W-1:0] x);
    return x * LCG_A + LCG_C;
  endfunction

endpackage

[rtl/stlb_mod.sv]
// Victim remainder unit: 32-bit source modulo the TLB depth, one digit per step.
// Depends on stlb_pkg.
module stlb_mod (
  input  logic                         clk_i,
  input  logic                         load_i,
  input  logic                         step_i,
  input  logic                         is_data_i,
  input  logic [stlb_pkg::SEED_W-1:0]  src_i,
  output logic [stlb_pkg::REM_W-1:0]   rem_o
);

  localparam int MW = stlb_pkg::REM_W + stlb_pkg::MOD_DIGIT;

  logic [stlb_pkg::SEED_W-1:0] src_q, src_d;
  logic [stlb_pkg::REM_W-1:0]  rem_q, rem_d;
  logic [MW-1:0]               part;
  logic [MW-1:0]               sub;
  logic [MW-1:0]               mult;

  // part < 16*depth since rem < depth; pick the largest multiple not above it
  always_comb begin
    part = {rem_q, src_q[stlb_pkg::SEED_W-1 -: stlb_pkg::MOD_DIGIT]};
    sub  = '0;
    mult = '0;
    for (int k = 1; k < (1 << stlb_pkg::MOD_DIGIT); k++) begin
      mult = is_data_i ? MW'(stlb_pkg::DATA_ENTRIES * k) : MW'(stlb_pkg::INST_ENTRIES * k);
      if (part >= mult) sub = mult;
    end
    rem_d = stlb_pkg::REM_W'(part - sub);
    src_d = {src_q[stlb_pkg::SEED_W-stlb_pkg::MOD_DIGIT-1:0], {stlb_pkg::MOD_DIGIT{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      src_q <= src_i;
      rem_q <= '0;
    end else if (step_i) begin
      src_q <= src_d;
      rem_q <= rem_d;
    end
  end

  assign rem_o = rem_q;

endmodule

[rtl/stlb_dp.sv]
// TLB datapath: config registers, entry arrays, associative match, victim
// counters and LCG, remainder unit, result register. Depends on stlb_pkg, stlb_mod.
module stlb_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  stlb_pkg::stlb_cmd_t              cmd_i,
  output stlb_pkg::stlb_status_t           status_o,
  input  logic                             action_i,
  input  logic [stlb_pkg::VADDR_W-1:0]     vaddr_i,
  input  logic                             walk_present_i,
  input  logic [stlb_pkg::FRAME_W-1:0]     walk_frame_i,
  input  logic                             cfg_we_i,
  input  logic [stlb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [stlb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                             done_o,
  output logic [stlb_pkg::FRAME_W-1:0]     frame_o,
  output logic                             hit_o,
  output logic                             fault_o,
  output logic signed [stlb_pkg::LAT_W-1:0] latency_o
);

  localparam int IE = stlb_pkg::INST_ENTRIES;
  localparam int DE = stlb_pkg::DATA_ENTRIES;

  // config
  logic [stlb_pkg::CLAT_W-1:0] inst_lat_q, data_lat_q, walk_lat_q;
  logic [stlb_pkg::MODE_W-1:0] mode_q;

  // victim state
  logic [stlb_pkg::SEED_W-1:0] icnt_q, icnt_d, dcnt_q, dcnt_d, rand_q, rand_d;
  logic                        seed_pend_q;

  // request
  logic                        is_data_q;
  logic [stlb_pkg::PAGE_W-1:0] page_q;
  logic                        present_q;
  logic [stlb_pkg::FRAME_W-1:0] wframe_q;

  // entries
  logic [IE-1:0]               inst_valid_q;
  logic [stlb_pkg::PAGE_W-1:0] inst_page_q  [IE];
  logic [stlb_pkg::FRAME_W-1:0] inst_frame_q [IE];
  logic [DE-1:0]               data_valid_q;
  logic [stlb_pkg::PAGE_W-1:0] data_page_q  [DE];
  logic [stlb_pkg::FRAME_W-1:0] data_frame_q [DE];

  // result
  logic                        done_q;
  logic [stlb_pkg::FRAME_W-1:0] frame_q;
  logic                        hit_q, fault_q;
  logic [stlb_pkg::LAT_W-1:0]  lat_q;

  logic                        i_hit, i_full, d_hit, d_full;
  logic [stlb_pkg::INST_IW-1:0] i_hit_idx, i_free_idx, i_wr_idx;
  logic [stlb_pkg::DATA_IW-1:0] d_hit_idx, d_free_idx, d_wr_idx;
  logic                        sel_hit, sel_full, i_we, d_we;
  logic [stlb_pkg::FRAME_W-1:0] hit_frame;
  logic [stlb_pkg::CLAT_W-1:0] hit_lat;
  logic [stlb_pkg::LAT_W-1:0]  miss_lat;
  logic [stlb_pkg::SEED_W-1:0] mod_src;
  logic [stlb_pkg::REM_W-1:0]  rem;

  always_comb begin
    i_hit = 1'b0; i_hit_idx = '0; i_full = 1'b1; i_free_idx = '0;
    for (int k = IE - 1; k >= 0; k--) begin
      if (inst_valid_q[k] && inst_page_q[k] == page_q) begin
        i_hit = 1'b1;
        i_hit_idx = stlb_pkg::INST_IW'(k);
      end
      if (!inst_valid_q[k]) begin
        i_full = 1'b0;
        i_free_idx = stlb_pkg::INST_IW'(k);
      end
    end
  end

  always_comb begin
    d_hit = 1'b0; d_hit_idx = '0; d_full = 1'b1; d_free_idx = '0;
    for (int k = DE - 1; k >= 0; k--) begin
      if (data_valid_q[k] && data_page_q[k] == page_q) begin
        d_hit = 1'b1;
        d_hit_idx = stlb_pkg::DATA_IW'(k);
      end
      if (!data_valid_q[k]) begin
        d_full = 1'b0;
        d_free_idx = stlb_pkg::DATA_IW'(k);
      end
    end
  end

  assign sel_hit   = is_data_q ? d_hit : i_hit;
  assign sel_full  = is_data_q ? d_full : i_full;
  assign hit_frame = is_data_q ? data_frame_q[d_hit_idx] : inst_frame_q[i_hit_idx];
  assign hit_lat   = is_data_q ? data_lat_q : inst_lat_q;
  assign miss_lat  = stlb_pkg::LAT_W'(hit_lat) + stlb_pkg::LAT_W'(walk_lat_q);

  assign status_o.hit      = sel_hit;
  assign status_o.present  = present_q;
  assign status_o.full     = sel_full;
  assign status_o.need_mod = (mode_q == stlb_pkg::EVICT_SEQ) || (mode_q == stlb_pkg::EVICT_LCG);

  assign i_wr_idx = i_full ? (cmd_i.use_rem ? rem[stlb_pkg::INST_IW-1:0] : '0) : i_free_idx;
  assign d_wr_idx = d_full ? (cmd_i.use_rem ? rem[stlb_pkg::DATA_IW-1:0] : '0) : d_free_idx;
  assign i_we = cmd_i.finish && !is_data_q && !i_hit && present_q;
  assign d_we = cmd_i.finish &&  is_data_q && !d_hit && present_q;

  assign mod_src = (mode_q == stlb_pkg::EVICT_SEQ) ? (is_data_q ? dcnt_q : icnt_q) : rand_q;

  stlb_mod u_mod (
    .clk_i     (clk_i),
    .load_i    (cmd_i.mod_load),
    .step_i    (cmd_i.mod_step),
    .is_data_i (is_data_q),
    .src_i     (mod_src),
    .rem_o     (rem)
  );

  // victim counters and LCG
  always_comb begin
    icnt_d = icnt_q;
    dcnt_d = dcnt_q;
    rand_d = rand_q;
    if (cfg_we_i && cfg_idx_i == stlb_pkg::CFG_SEED) begin
      rand_d = cfg_data_i;
      icnt_d = stlb_pkg::lcg_next(cfg_data_i);
    end else if (cmd_i.mod_load) begin
      if (mode_q == stlb_pkg::EVICT_SEQ) begin
        if (is_data_q) dcnt_d = dcnt_q + 32'd1;
        else           icnt_d = icnt_q + 32'd1;
      end else begin
        rand_d = stlb_pkg::lcg_next(rand_q);
      end
    end
    // data counter is one LCG step past the inst counter after a seed load
    if (seed_pend_q) dcnt_d = stlb_pkg::lcg_next(icnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inst_lat_q   <= stlb_pkg::INST_LAT_RST;
      data_lat_q   <= stlb_pkg::DATA_LAT_RST;
      walk_lat_q   <= stlb_pkg::WALK_LAT_RST;
      mode_q       <= stlb_pkg::EVICT_SEQ;
      icnt_q       <= stlb_pkg::INST_CNT_RST;
      dcnt_q       <= stlb_pkg::DATA_CNT_RST;
      rand_q       <= '0;
      seed_pend_q  <= 1'b0;
      inst_valid_q <= '0;
      data_valid_q <= '0;
      done_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          stlb_pkg::CFG_INST_LAT: inst_lat_q <= cfg_data_i[stlb_pkg::CLAT_W-1:0];
          stlb_pkg::CFG_DATA_LAT: data_lat_q <= cfg_data_i[stlb_pkg::CLAT_W-1:0];
          stlb_pkg::CFG_WALK_LAT: walk_lat_q <= cfg_data_i[stlb_pkg::CLAT_W-1:0];
          stlb_pkg::CFG_EVICT:    mode_q     <= cfg_data_i[stlb_pkg::MODE_W-1:0];
          default: ;
        endcase
      end
      icnt_q      <= icnt_d;
      dcnt_q      <= dcnt_d;
      rand_q      <= rand_d;
      seed_pend_q <= cfg_we_i && cfg_idx_i == stlb_pkg::CFG_SEED;
      if (i_we) inst_valid_q[i_wr_idx] <= 1'b1;
      if (d_we) data_valid_q[d_wr_idx] <= 1'b1;
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      is_data_q <= action_i;
      page_q    <= vaddr_i[stlb_pkg::VADDR_W-1 -: stlb_pkg::PAGE_W];
      present_q <= walk_present_i;
      wframe_q  <= walk_frame_i & stlb_pkg::FRAME_MASK;
    end
    if (i_we) begin
      inst_page_q[i_wr_idx]  <= page_q;
      inst_frame_q[i_wr_idx] <= wframe_q;
    end
    if (d_we) begin
      data_page_q[d_wr_idx]  <= page_q;
      data_frame_q[d_wr_idx] <= wframe_q;
    end
    if (cmd_i.finish) begin
      if (sel_hit) begin
        frame_q <= hit_frame & stlb_pkg::FRAME_MASK;
        hit_q   <= 1'b1;
        fault_q <= 1'b0;
        lat_q   <= stlb_pkg::LAT_W'(hit_lat);
      end else if (!present_q) begin
        frame_q <= '0;
        hit_q   <= 1'b0;
        fault_q <= 1'b1;
        lat_q   <= {stlb_pkg::LAT_W{1'b1}};
      end else begin
        frame_q <= wframe_q;
        hit_q   <= 1'b0;
        fault_q <= 1'b0;
        lat_q   <= miss_lat;
      end
    end
  end

  assign done_o    = done_q;
  assign frame_o   = frame_q;
  assign hit_o     = hit_q;
  assign fault_o   = fault_q;
  assign latency_o = signed'(lat_q);

endmodule

[rtl/stlb_ctrl.sv]
// TLB controller: request sequencing over lookup, victim modulo and refill.
// Depends on stlb_pkg.
module stlb_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  stlb_pkg::stlb_status_t  status_i,
  output stlb_pkg::stlb_cmd_t     cmd_o
);

  stlb_pkg::stlb_state_e          state_q, state_d;
  logic [stlb_pkg::STEP_W-1:0]    step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stlb_pkg::S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      stlb_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d = stlb_pkg::S_LOOKUP;
        end
      end
      stlb_pkg::S_LOOKUP: begin
        // full TLB, mapped page, counter or LCG victim: reduce modulo depth first
        if (!status_i.hit && status_i.present && status_i.full && status_i.need_mod) begin
          cmd_o.mod_load = 1'b1;
          step_d  = '0;
          state_d = stlb_pkg::S_MOD;
        end else begin
          cmd_o.finish = 1'b1;
          state_d = stlb_pkg::S_IDLE;
        end
      end
      stlb_pkg::S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (step_q == stlb_pkg::STEP_W'(stlb_pkg::MOD_STEPS - 1)) begin
          state_d = stlb_pkg::S_EVICT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      stlb_pkg::S_EVICT: begin
        cmd_o.finish  = 1'b1;
        cmd_o.use_rem = 1'b1;
        state_d = stlb_pkg::S_IDLE;
      end
      default: state_d = stlb_pkg::S_IDLE;
    endcase
  end

  assign busy = (state_q != stlb_pkg::S_IDLE);

endmodule

[rtl/split_tlb_lookup_refill.sv]
// Split instruction/data TLB with refill. done_o rises in the cycle after the accepting
// edge (hit, fault, fill, entry-zero eviction); when a full TLB evicts by counter or LCG,
// the load, the 8-step victim modulo in stlb_mod and the evict state come first; busy
// covers accept to result load, and no new request is taken while busy.
// Reset clears valid bits, loads register defaults and seed zero; entries are not cleared.
// The receiver cannot stall: each result is shown for one cycle only.
module split_tlb_lookup_refill (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                action_i,
  input  logic [stlb_pkg::VADDR_W-1:0]        vaddr_i,
  input  logic                                walk_present_i,
  input  logic [stlb_pkg::FRAME_W-1:0]        walk_frame_i,
  input  logic                                cfg_we_i,
  input  logic [stlb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [stlb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                done_o,
  output logic [stlb_pkg::FRAME_W-1:0]        frame_o,
  output logic                                hit_o,
  output logic                                fault_o,
  output logic signed [stlb_pkg::LAT_W-1:0]   latency_o
);

  stlb_pkg::stlb_cmd_t    cmd;
  stlb_pkg::stlb_status_t status;

  stlb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  stlb_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .action_i       (action_i),
    .vaddr_i        (vaddr_i),
    .walk_present_i (walk_present_i),
    .walk_frame_i   (walk_frame_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .frame_o        (frame_o),
    .hit_o          (hit_o),
    .fault_o        (fault_o),
    .latency_o      (latency_o)
  );

`ifndef SYNTHESIS
  a_fault_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && fault_o |-> !hit_o && latency_o == -10'sd1 && frame_o == '0)
    else $error("fault result malformed");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a request in flight");

  a_hit_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit_o |-> !fault_o && latency_o[9:8] == 2'b00)
    else $error("hit latency out of range");
`endif

endmodule

[dv/tb_split_tlb_lookup_refill.sv]
`timescale 1ns / 1ps
// Testbench for split_tlb_lookup_refill: directed and random translation requests
// checked against an in-bench TLB model held in a scoreboard class. Depends on stlb_pkg.
module tb_split_tlb_lookup_refill;

  // unused code, acts as entry zero
  localparam logic [stlb_pkg::MODE_W-1:0] EVICT_SPARE = 2'd3;
  localparam int POOL_PAGES  = 24;                   // more pages than entries: forces refills
  localparam int LATENCY_PAD = 16;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [stlb_pkg::FRAME_W-1:0]      frame;
    logic                              hit;
    logic                              fault;
    logic signed [stlb_pkg::LAT_W-1:0] latency;
  } xlate_t;

  class xlate_scoreboard;
    xlate_t                       pending_xlate[$];
    int unsigned                  mismatches;
    logic [stlb_pkg::CLAT_W-1:0]  hit_lat[2];       // [0] instruction, [1] data
    logic [stlb_pkg::CLAT_W-1:0]  walk_lat;
    logic [stlb_pkg::MODE_W-1:0]  evict_mode;
    logic [stlb_pkg::SEED_W-1:0]  lcg_state;
    logic [stlb_pkg::SEED_W-1:0]  victim_cnt[2];
    bit                           entry_vld[2][stlb_pkg::MAX_ENTRIES];
    logic [stlb_pkg::PAGE_W-1:0]  entry_page[2][stlb_pkg::MAX_ENTRIES];
    logic [stlb_pkg::FRAME_W-1:0] entry_frame[2][stlb_pkg::MAX_ENTRIES];

    function logic [stlb_pkg::SEED_W-1:0] lcg_advance(logic [stlb_pkg::SEED_W-1:0] x);
      return x * stlb_pkg::LCG_A + stlb_pkg::LCG_C;
    endfunction

    function void reseed(logic [stlb_pkg::SEED_W-1:0] s);
      lcg_state     = s;
      victim_cnt[0] = lcg_advance(s);
      victim_cnt[1] = lcg_advance(victim_cnt[0]);
    endfunction

    function void power_on();
      foreach (entry_vld[t, k]) entry_vld[t][k] = 1'b0;
      hit_lat[0] = stlb_pkg::INST_LAT_RST;
      hit_lat[1] = stlb_pkg::DATA_LAT_RST;
      walk_lat   = stlb_pkg::WALK_LAT_RST;
      evict_mode = stlb_pkg::EVICT_SEQ;
      reseed('0);
      mismatches = 0;
    endfunction

    function void apply_reg(logic [stlb_pkg::CFG_IDX_W-1:0] idx,
                            logic [stlb_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        stlb_pkg::CFG_INST_LAT: hit_lat[0] = val[stlb_pkg::CLAT_W-1:0];
        stlb_pkg::CFG_DATA_LAT: hit_lat[1] = val[stlb_pkg::CLAT_W-1:0];
        stlb_pkg::CFG_WALK_LAT: walk_lat   = val[stlb_pkg::CLAT_W-1:0];
        stlb_pkg::CFG_EVICT:    evict_mode = val[stlb_pkg::MODE_W-1:0];
        stlb_pkg::CFG_SEED:     reseed(val[stlb_pkg::SEED_W-1:0]);
        default: ;
      endcase
    endfunction

    function int outstanding();
      return pending_xlate.size();
    endfunction

    function void note_request(bit is_data, logic [stlb_pkg::VADDR_W-1:0] va, bit present,
                               logic [stlb_pkg::FRAME_W-1:0] wf);
      int unsigned                  t;
      int unsigned                  depth;
      int unsigned                  slot;
      logic [stlb_pkg::PAGE_W-1:0]  page;
      logic [stlb_pkg::SEED_W-1:0]  pick;
      logic [stlb_pkg::FRAME_W-1:0] fr;
      xlate_t                       want;
      t     = is_data;
      depth = is_data ? stlb_pkg::DATA_ENTRIES : stlb_pkg::INST_ENTRIES;
      page  = va[stlb_pkg::VADDR_W-1:12];
      for (int k = 0; k < depth; k++) begin
        if (entry_vld[t][k] && entry_page[t][k] == page) begin
          want.frame   = entry_frame[t][k] & stlb_pkg::FRAME_MASK;
          want.hit     = 1'b1;
          want.fault   = 1'b0;
          want.latency = stlb_pkg::LAT_W'(hit_lat[t]);
          pending_xlate.push_back(want);
          return;
        end
      end
      if (!present) begin
        want.frame   = '0;
        want.hit     = 1'b0;
        want.fault   = 1'b1;
        want.latency = '1;
        pending_xlate.push_back(want);
        return;
      end
      fr           = wf & stlb_pkg::FRAME_MASK;
      want.frame   = fr;
      want.hit     = 1'b0;
      want.fault   = 1'b0;
      want.latency = stlb_pkg::LAT_W'(hit_lat[t]) + stlb_pkg::LAT_W'(walk_lat);
      pending_xlate.push_back(want);
      for (int k = 0; k < depth; k++) begin
        if (!entry_vld[t][k]) begin
          entry_vld[t][k]   = 1'b1;
          entry_page[t][k]  = page;
          entry_frame[t][k] = fr;
          return;
        end
      end
      // full: replace, entry stays valid
      pick = '0;
      if (evict_mode == stlb_pkg::EVICT_SEQ) begin
        pick          = victim_cnt[t];
        victim_cnt[t] = victim_cnt[t] + 32'd1;
      end else if (evict_mode == stlb_pkg::EVICT_LCG) begin
        pick      = lcg_state;
        lcg_state = lcg_advance(lcg_state);
      end
      slot = pick % depth;
      entry_page[t][slot]  = page;
      entry_frame[t][slot] = fr;
    endfunction

    function void check_result(xlate_t got);
      xlate_t want;
      if (pending_xlate.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request pending: frame %h hit %b fault %b latency %0d",
                 $time, got.frame, got.hit, got.fault, got.latency);
        return;
      end
      want = pending_xlate.pop_front();
      if (got.frame !== want.frame) begin
        mismatches++;
        $display("%0t: frame mismatch: expected %h, actual %h", $time, want.frame, got.frame);
      end
      if (got.hit !== want.hit) begin
        mismatches++;
        $display("%0t: hit mismatch: expected %b, actual %b", $time, want.hit, got.hit);
      end
      if (got.fault !== want.fault) begin
        mismatches++;
        $display("%0t: fault mismatch: expected %b, actual %b", $time, want.fault, got.fault);
      end
      if (got.latency !== want.latency) begin
        mismatches++;
        $display("%0t: latency mismatch: expected %0d, actual %0d",
                 $time, want.latency, got.latency);
      end
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              start;
  logic                              busy;
  logic                              action_i;
  logic [stlb_pkg::VADDR_W-1:0]      vaddr_i;
  logic                              walk_present_i;
  logic [stlb_pkg::FRAME_W-1:0]      walk_frame_i;
  logic                              cfg_we_i;
  logic [stlb_pkg::CFG_IDX_W-1:0]    cfg_idx_i;
  logic [stlb_pkg::CFG_DATA_W-1:0]   cfg_data_i;
  logic                              done_o;
  logic [stlb_pkg::FRAME_W-1:0]      frame_o;
  logic                              hit_o;
  logic                              fault_o;
  logic signed [stlb_pkg::LAT_W-1:0] latency_o;

  xlate_scoreboard sb;
  int unsigned     stall_cycles;

  split_tlb_lookup_refill dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .vaddr_i        (vaddr_i),
    .walk_present_i (walk_present_i),
    .walk_frame_i   (walk_frame_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .frame_o        (frame_o),
    .hit_o          (hit_o),
    .fault_o        (fault_o),
    .latency_o      (latency_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_result(xlate_t'{frame_o, hit_o, fault_o, latency_o});
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o || cfg_we_i) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("[split_tlb_lookup_refill] ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_xlate(bit is_data, logic [stlb_pkg::VADDR_W-1:0] va, bit present,
                            logic [stlb_pkg::FRAME_W-1:0] wf);
    @(negedge clk_i);
    start          = 1'b1;
    action_i       = is_data;
    vaddr_i        = va;
    walk_present_i = present;
    walk_frame_i   = wf;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(is_data, va, present, wf);
  endtask

  task automatic gap(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start = 1'b0;
    end
  endtask

  // hold off new requests until every translation has come back
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [stlb_pkg::CFG_IDX_W-1:0] idx,
                           logic [stlb_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    start      = 1'b0;
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    sb.apply_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // upper data bits carry junk; the block keeps only the register width
  task automatic load_regs(logic [stlb_pkg::CLAT_W-1:0] ilat, logic [stlb_pkg::CLAT_W-1:0] dlat,
                           logic [stlb_pkg::CLAT_W-1:0] wlat, logic [stlb_pkg::MODE_W-1:0] mode,
                           logic [stlb_pkg::SEED_W-1:0] seed_val);
    drain();
    repeat (LATENCY_PAD) @(negedge clk_i);
    cfg_write(stlb_pkg::CFG_INST_LAT,
              {(stlb_pkg::CFG_DATA_W-stlb_pkg::CLAT_W)'($urandom()), ilat});
    cfg_write(stlb_pkg::CFG_DATA_LAT,
              {(stlb_pkg::CFG_DATA_W-stlb_pkg::CLAT_W)'($urandom()), dlat});
    cfg_write(stlb_pkg::CFG_WALK_LAT,
              {(stlb_pkg::CFG_DATA_W-stlb_pkg::CLAT_W)'($urandom()), wlat});
    cfg_write(stlb_pkg::CFG_EVICT,
              {(stlb_pkg::CFG_DATA_W-stlb_pkg::MODE_W)'($urandom()), mode});
    cfg_write(stlb_pkg::CFG_SEED, seed_val);
  endtask

  task automatic directed_checks();
    send_xlate(1'b0, 32'h0000_0000, 1'b0, 20'h00000);  // empty TLB, no page
    send_xlate(1'b0, 32'hFFFF_FFFF, 1'b1, 20'hFFFFF);
    send_xlate(1'b0, 32'hFFFF_F000, 1'b0, 20'h00000);  // hit ignores walk result
    send_xlate(1'b1, 32'hFFFF_F800, 1'b0, 20'h5A5A5);  // data side holds no copy
    send_xlate(1'b1, 32'hFFFF_F800, 1'b1, 20'h00000);
    send_xlate(1'b1, 32'hFFFF_FFFF, 1'b0, 20'hFFFFF);
    send_xlate(1'b0, 32'h0000_0FFF, 1'b1, 20'hAAAAA);
    send_xlate(1'b0, 32'h0000_0123, 1'b1, 20'h55555);
    // fill the data side, then two counter evictions
    for (int k = 0; k < 17; k++) begin
      send_xlate(1'b1, {stlb_pkg::PAGE_W'(32'h10000 + k), 12'(k)}, 1'b1,
                 stlb_pkg::FRAME_W'(32'h80000 + k));
    end
  endtask

  task automatic random_phase(int unsigned n_items, int unsigned idle_pct);
    logic [stlb_pkg::PAGE_W-1:0]  pages[POOL_PAGES];
    logic [stlb_pkg::VADDR_W-1:0] va;
    foreach (pages[i]) pages[i] = stlb_pkg::PAGE_W'($urandom());
    for (int unsigned i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < idle_pct) gap($urandom_range(1, 4));
      if ($urandom_range(59) == 0) drain();
      if ($urandom_range(99) < 8) va = $urandom();
      else va = {pages[$urandom_range(POOL_PAGES-1)], 12'($urandom())};
      send_xlate($urandom_range(1), va, $urandom_range(99) < 88,
                 stlb_pkg::FRAME_W'($urandom()));
    end
  endtask

  initial begin
    sb = new;
    sb.power_on();
    stall_cycles   = 0;
    rst_ni         = 1'b0;
    start          = 1'b0;
    action_i       = 1'b0;
    vaddr_i        = '0;
    walk_present_i = 1'b0;
    walk_frame_i   = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed_checks();

    load_regs(8'd255, 8'd255, 8'd255, stlb_pkg::EVICT_SEQ, 32'hFFFF_FFFF);
    random_phase(240, 38);
    load_regs(8'd0, 8'd0, 8'd0, stlb_pkg::EVICT_LCG, $urandom());
    random_phase(240, 38);
    load_regs(8'($urandom()), 8'($urandom()), 8'($urandom()), stlb_pkg::EVICT_ZERO,
              $urandom());
    random_phase(240, 59);
    load_regs(8'($urandom()), 8'($urandom()), 8'($urandom()), EVICT_SPARE, 32'h0);
    random_phase(240, 59);
    load_regs(8'($urandom()), 8'($urandom()), 8'($urandom()), stlb_pkg::EVICT_SEQ,
              $urandom());
    random_phase(240, 0);
    load_regs(8'($urandom()), 8'($urandom()), 8'($urandom()), stlb_pkg::EVICT_LCG,
              $urandom());
    random_phase(240, 0);

    drain();
    repeat (LATENCY_PAD) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("[split_tlb_lookup_refill] OK");
    end else begin
      $display("[split_tlb_lookup_refill] ERROR");
    end
    $finish;
  end

endmodule
